// ===== rtl/core/sflc_pkg.sv =====
// Shared types, codes and constants of the supervision frame link controller.
`timescale 1ns / 1ps
package sflc_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] FRAME_FLAG = 8'h7e;
  localparam logic [7:0] FRAME_ADDR = 8'h03;
  localparam logic [7:0] CTL_SET_BYTE = 8'h03;
  localparam logic [7:0] CTL_UA_BYTE = 8'h07;
  localparam logic [7:0] CTL_DISC_BYTE = 8'h0B;

  localparam logic [7:0] TIMEOUT_RESET = 8'd3;
  localparam logic [3:0] ATTEMPTS_RESET = 4'd3;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_BYTE = 2'd1;
  localparam logic [1:0] ACT_OPEN = 2'd2;
  localparam logic [1:0] ACT_CLOSE = 2'd3;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_ATTEMPTS = 1'b1;

  localparam logic [2:0] LAST_BEAT = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_OPENING = 3'd1,
    PH_OPEN = 3'd2,
    PH_CLOSING = 3'd3,
    PH_CLOSED = 3'd4,
    PH_FAILED = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    RX_START = 3'd0,
    RX_FLAG = 3'd1,
    RX_ADDR = 3'd2,
    RX_CTRL = 3'd3,
    RX_BCC = 3'd4
  } rx_state_t;

  typedef enum logic [1:0] {
    CTL_SET = 2'd0,
    CTL_UA = 2'd1,
    CTL_DISC = 2'd2
  } ctl_t;

  typedef struct packed {
    logic frame;
    ctl_t ctl;
    phase_t status;
  } job_t;

  function automatic logic [7:0] ctl_byte(input ctl_t c);
    logic [7:0] b;
    case (c)
      CTL_SET: b = CTL_SET_BYTE;
      CTL_UA: b = CTL_UA_BYTE;
      CTL_DISC: b = CTL_DISC_BYTE;
      default: b = CTL_SET_BYTE;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] frame_byte(input ctl_t c, input logic [2:0] beat);
    logic [7:0] b;
    case (beat)
      3'd0: b = FRAME_FLAG;
      3'd1: b = FRAME_ADDR;
      3'd2: b = ctl_byte(c);
      3'd3: b = FRAME_ADDR ^ ctl_byte(c);
      3'd4: b = FRAME_FLAG;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/sflc_intf.sv =====
// Channel interfaces: input requests, result requests and configuration writes.
`timescale 1ns / 1ps
interface sflc_in_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  modport source(output valid, action, rx_byte, input ready);
  modport sink(input valid, action, rx_byte, output ready);
endinterface

interface sflc_out_if;
  logic valid;
  logic ready;
  logic [7:0] tx_byte;
  logic tx_valid;
  logic last;
  logic [2:0] link_status;
  modport source(output valid, tx_byte, tx_valid, last, link_status, input ready);
  modport sink(input valid, tx_byte, tx_valid, last, link_status, output ready);
endinterface

interface sflc_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [7:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/sflc_front.sv =====
// Front end: accepts requests, runs link and receiver state, emits jobs.
`timescale 1ns / 1ps
module sflc_front (
  input  logic clk,
  input  logic rst,
  sflc_in_if.sink in_ch,
  input  logic [7:0] timeout_ticks,
  input  logic [3:0] max_attempts,
  input  logic q_full,
  output logic push,
  output sflc_pkg::job_t job
);
  import sflc_pkg::*;

  phase_t phase, phase_next;
  rx_state_t rx_state, rx_state_next, feed_next;
  logic [7:0] seen_address, seen_address_next, feed_address;
  logic [7:0] seen_control, seen_control_next, feed_control;
  logic [7:0] tick_count, tick_count_next, tick_inc;
  logic [3:0] attempt_count, attempt_count_next;
  logic feed_match;
  logic busy;
  logic [7:0] want;
  logic [7:0] b;

  assign in_ch.ready = !q_full;
  assign push = in_ch.valid && !q_full;
  assign b = in_ch.rx_byte;
  assign busy = (phase == PH_OPENING) || (phase == PH_CLOSING);
  assign want = (phase == PH_OPENING) ? CTL_UA_BYTE : CTL_DISC_BYTE;
  assign tick_inc = (tick_count == 8'hff) ? tick_count : tick_count + 8'd1;

  // receiver machine
  always_comb begin
    feed_next = RX_START;
    feed_address = seen_address;
    feed_control = seen_control;
    feed_match = 1'b0;
    case (rx_state)
      RX_FLAG: begin
        if (b == FRAME_ADDR) begin
          feed_address = b;
          feed_next = RX_ADDR;
        end else if (b == FRAME_FLAG) begin
          feed_next = RX_FLAG;
        end
      end
      RX_ADDR: begin
        if (b == want) begin
          feed_control = b;
          feed_next = RX_CTRL;
        end else if (b == FRAME_FLAG) begin
          feed_next = RX_FLAG;
        end
      end
      RX_CTRL: begin
        if (b == (seen_address ^ seen_control)) begin
          feed_next = RX_BCC;
        end else if (b == FRAME_FLAG) begin
          feed_next = RX_FLAG;
        end
      end
      RX_BCC: begin
        feed_match = (b == FRAME_FLAG);
      end
      default: begin
        if (b == FRAME_FLAG) feed_next = RX_FLAG;
      end
    endcase
  end

  always_comb begin
    phase_next = phase;
    rx_state_next = rx_state;
    seen_address_next = seen_address;
    seen_control_next = seen_control;
    tick_count_next = tick_count;
    attempt_count_next = attempt_count;
    job.frame = 1'b0;
    job.ctl = CTL_SET;
    case (in_ch.action)
      ACT_OPEN: begin
        if (phase inside {PH_IDLE, PH_CLOSED, PH_FAILED}) begin
          phase_next = PH_OPENING;
          attempt_count_next = 4'd1;
          tick_count_next = 8'd0;
          rx_state_next = RX_START;
          job.frame = 1'b1;
          job.ctl = CTL_SET;
        end
      end
      ACT_CLOSE: begin
        if (phase == PH_OPEN) begin
          phase_next = PH_CLOSING;
          attempt_count_next = 4'd1;
          tick_count_next = 8'd0;
          rx_state_next = RX_START;
          job.frame = 1'b1;
          job.ctl = CTL_DISC;
        end
      end
      ACT_BYTE: begin
        if (busy) begin
          rx_state_next = feed_next;
          seen_address_next = feed_address;
          seen_control_next = feed_control;
          if (feed_match) begin
            tick_count_next = 8'd0;
            if (phase == PH_OPENING) begin
              phase_next = PH_OPEN;
            end else begin
              phase_next = PH_CLOSED;
              job.frame = 1'b1;
              job.ctl = CTL_UA;
            end
          end
        end
      end
      default: begin
        if (busy) begin
          tick_count_next = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            tick_count_next = 8'd0;
            rx_state_next = RX_START;
            if (attempt_count < max_attempts) begin
              attempt_count_next = attempt_count + 4'd1;
              job.frame = 1'b1;
              job.ctl = (phase == PH_OPENING) ? CTL_SET : CTL_DISC;
            end else if (phase == PH_OPENING) begin
              phase_next = PH_FAILED;
            end else begin
              phase_next = PH_CLOSED;
              job.frame = 1'b1;
              job.ctl = CTL_UA;
            end
          end
        end
      end
    endcase
    job.status = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      rx_state <= RX_START;
      seen_address <= 8'd0;
      seen_control <= 8'd0;
      tick_count <= 8'd0;
      attempt_count <= 4'd0;
    end else if (push) begin
      phase <= phase_next;
      rx_state <= rx_state_next;
      seen_address <= seen_address_next;
      seen_control <= seen_control_next;
      tick_count <= tick_count_next;
      attempt_count <= attempt_count_next;
    end
  end

endmodule

// ===== rtl/core/sflc_queue.sv =====
// Job queue between the front end and the frame serializer.
`timescale 1ns / 1ps
module sflc_queue #(
  parameter int DEPTH = sflc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  sflc_pkg::job_t wr_job,
  input  logic pop,
  output sflc_pkg::job_t rd_job,
  output logic full,
  output logic empty
);
  import sflc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

  job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == COUNT_FULL);
  assign empty = (count == '0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/core/sflc_back.sv =====
// Back end: turns jobs into five-byte frames or single status results.
`timescale 1ns / 1ps
module sflc_back (
  input  logic clk,
  input  logic rst,
  input  sflc_pkg::job_t head,
  input  logic q_empty,
  output logic pop,
  sflc_out_if.source out_ch
);
  import sflc_pkg::*;

  job_t cur;
  logic cur_valid;
  logic [2:0] beat;
  logic is_last;
  logic fire;
  logic load;

  assign is_last = !cur.frame || (beat == LAST_BEAT);
  assign fire = out_ch.valid && out_ch.ready;
  assign load = !cur_valid || (fire && is_last);
  assign pop = load && !q_empty;

  assign out_ch.valid = cur_valid;
  assign out_ch.tx_byte = cur.frame ? frame_byte(cur.ctl, beat) : 8'h00;
  assign out_ch.tx_valid = cur.frame;
  assign out_ch.last = is_last;
  assign out_ch.link_status = cur.status;

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      beat <= 3'd0;
    end else if (load) begin
      cur_valid <= !q_empty;
      beat <= 3'd0;
    end else if (fire) begin
      beat <= beat + 3'd1;
    end
  end

endmodule

// ===== rtl/core/supervision_frame_link_control_core.sv =====
// Top level of the supervision frame link controller.
`timescale 1ns / 1ps
// Link-setup controller, transmitter side, for HDLC-like supervisory frames.
// in_ch:  one request per item: action (tick, received byte, open, close)
//         and rx_byte. in_ch.ready drops only when the job queue is full.
// out_ch: results. A frame-sending item yields five requests (the frame
//         bytes, tx_valid high, last on the closing flag); any other item
//         yields one status request with tx_valid low and last high.
//         link_status carries the link phase after the item.
// cfg:    register writes (0 timeout_ticks, 1 max_attempts), always ready;
//         the user writes them only while the block is idle; not enforced.
// Path:   an accepted item is written to the job queue, then loaded into
//         the serializer register, which offers its first result.
// Throughput: one item per cycle into the front end while the queue has room;
//         the serializer delivers one result per cycle while out_ch is ready.
// Stalls: a held out_ch stops the serializer; the queue of QUEUE_DEPTH
//         jobs fills and then in_ch.ready falls.
// Reset: link idle, receiver at start, counters cleared, registers at 3/3,
//         queue and serializer emptied.
module supervision_frame_link_control_core #(
  parameter int QUEUE_DEPTH = sflc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  sflc_in_if.sink in_ch,
  sflc_out_if.source out_ch,
  sflc_cfg_if.sink cfg
);
  import sflc_pkg::*;

  logic [7:0] timeout_ticks;
  logic [3:0] max_attempts;
  logic q_full, q_empty, push, pop;
  job_t wr_job, head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      max_attempts <= ATTEMPTS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TIMEOUT: timeout_ticks <= cfg.data;
        REG_ATTEMPTS: max_attempts <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  sflc_front u_front (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .timeout_ticks(timeout_ticks),
    .max_attempts(max_attempts),
    .q_full(q_full),
    .push(push),
    .job(wr_job)
  );

  sflc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_job(wr_job),
    .pop(pop),
    .rd_job(head),
    .full(q_full),
    .empty(q_empty)
  );

  sflc_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .q_empty(q_empty),
    .pop(pop),
    .out_ch(out_ch)
  );

endmodule

// ===== verif/supervision_frame_link_control_core_tb.sv =====
// Self-checking testbench for the supervision frame link controller core.
`timescale 1ns / 1ps
module supervision_frame_link_control_core_tb;
  import sflc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic tx_valid;
    logic last;
    phase_t status;
  } tx_beat_t;

  logic clk;
  logic rst;

  sflc_in_if in_ch();
  sflc_out_if out_ch();
  sflc_cfg_if cfg();

  supervision_frame_link_control_core DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg)
  );

  phase_t link_phase;
  rx_state_t rx_at;
  logic [7:0] rx_addr_seen;
  logic [7:0] rx_ctl_seen;
  logic [7:0] wait_ticks;
  logic [7:0] timeout_reg;
  logic [3:0] sends_done;
  logic [3:0] attempts_reg;

  tx_beat_t tx_expected[$];
  tx_beat_t head_beat;

  int gap_pct;
  int stall_pct;
  int errors;
  int line_items;
  int results_checked;
  int links_opened;
  int links_failed;
  int settings_used;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void queue_status();
    tx_expected.push_back(tx_beat_t'{8'h00, 1'b0, 1'b1, link_phase});
  endfunction

  function automatic void queue_frame(input logic [7:0] ctl);
    logic [7:0] fr [5];
    fr = '{FRAME_FLAG, FRAME_ADDR, ctl, FRAME_ADDR ^ ctl, FRAME_FLAG};
    for (int k = 0; k < 5; k++) tx_expected.push_back(tx_beat_t'{fr[k], 1'b1, k == 4, link_phase});
  endfunction

  function automatic void restart_wait();
    wait_ticks = 8'd0;
    rx_at = RX_START;
  endfunction

  // line receiver; returns 1 on a complete frame carrying want
  function automatic bit rx_advance(input logic [7:0] b, input logic [7:0] want);
    bit matched;
    matched = 1'b0;
    case (rx_at)
      RX_FLAG: begin
        if (b == FRAME_ADDR) begin
          rx_addr_seen = b;
          rx_at = RX_ADDR;
        end else rx_at = (b == FRAME_FLAG) ? RX_FLAG : RX_START;
      end
      RX_ADDR: begin
        if (b == want) begin
          rx_ctl_seen = b;
          rx_at = RX_CTRL;
        end else rx_at = (b == FRAME_FLAG) ? RX_FLAG : RX_START;
      end
      RX_CTRL: begin
        if (b == (rx_addr_seen ^ rx_ctl_seen)) rx_at = RX_BCC;
        else rx_at = (b == FRAME_FLAG) ? RX_FLAG : RX_START;
      end
      RX_BCC: begin
        matched = (b == FRAME_FLAG);
        rx_at = RX_START;
      end
      default: rx_at = (b == FRAME_FLAG) ? RX_FLAG : RX_START;
    endcase
    return matched;
  endfunction

  function automatic bit acts_on_link(input logic [1:0] act);
    bit busy;
    busy = (link_phase == PH_OPENING) || (link_phase == PH_CLOSING);
    if (act == ACT_OPEN)
      return link_phase == PH_IDLE || link_phase == PH_CLOSED || link_phase == PH_FAILED;
    if (act == ACT_CLOSE) return link_phase == PH_OPEN;
    return busy;
  endfunction

  function automatic void predict_request(input logic [1:0] act, input logic [7:0] b);
    logic [7:0] want;
    want = (link_phase == PH_OPENING) ? CTL_UA_BYTE : CTL_DISC_BYTE;
    if (!acts_on_link(act)) begin
      queue_status();
    end else if (act == ACT_OPEN) begin
      link_phase = PH_OPENING;
      sends_done = 4'd1;
      restart_wait();
      queue_frame(CTL_SET_BYTE);
    end else if (act == ACT_CLOSE) begin
      link_phase = PH_CLOSING;
      sends_done = 4'd1;
      restart_wait();
      queue_frame(CTL_DISC_BYTE);
    end else if (act == ACT_BYTE) begin
      if (rx_advance(b, want)) begin
        wait_ticks = 8'd0;
        if (link_phase == PH_OPENING) begin
          link_phase = PH_OPEN;
          links_opened++;
          queue_status();
        end else begin
          link_phase = PH_CLOSED;
          queue_frame(CTL_UA_BYTE);
        end
      end else queue_status();
    end else begin
      if (wait_ticks != 8'd255) wait_ticks++;
      if (wait_ticks < timeout_reg) begin
        queue_status();
      end else begin
        wait_ticks = 8'd0;
        if (sends_done < attempts_reg) begin
          sends_done++;
          restart_wait();
          queue_frame((link_phase == PH_OPENING) ? CTL_SET_BYTE : CTL_DISC_BYTE);
        end else begin
          rx_at = RX_START;
          if (link_phase == PH_OPENING) begin
            link_phase = PH_FAILED;
            links_failed++;
            queue_status();
          end else begin
            // close gives up but still acknowledges
            link_phase = PH_CLOSED;
            queue_frame(CTL_UA_BYTE);
          end
        end
      end
    end
  endfunction

  task automatic send_request(input logic [1:0] act, input logic [7:0] b);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.rx_byte = b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (acts_on_link(act)) line_items++;
    predict_request(act, b);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_for_idle();
    while (tx_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] val);
    wait_for_idle();
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data = val;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    if (idx == REG_TIMEOUT) timeout_reg = val;
    else attempts_reg = val[3:0];
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    gap_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // line frame, optionally with a leading flag and one damaged byte
  task automatic send_line_frame(input logic [7:0] ctl, input bit clean);
    logic [7:0] bytes_out [5];
    int hit;
    bytes_out = '{FRAME_FLAG, FRAME_ADDR, ctl, FRAME_ADDR ^ ctl, FRAME_FLAG};
    if (!clean) begin
      if ($urandom_range(3) == 0) send_request(ACT_BYTE, FRAME_FLAG);
      if ($urandom_range(3) == 0) begin
        hit = $urandom_range(4);
        bytes_out[hit] = $urandom_range(1) ? FRAME_FLAG : 8'($urandom);
      end
    end
    foreach (bytes_out[k]) send_request(ACT_BYTE, bytes_out[k]);
  endtask

  task automatic random_request();
    int pick;
    logic [7:0] ctl;
    pick = $urandom_range(99);
    case (link_phase)
      PH_OPENING, PH_CLOSING: begin
        if (pick < 40) begin
          ctl = (link_phase == PH_OPENING) ? CTL_UA_BYTE : CTL_DISC_BYTE;
          if ($urandom_range(4) == 0) begin
            case ($urandom_range(2))
              0: ctl = CTL_SET_BYTE;
              1: ctl = CTL_UA_BYTE;
              default: ctl = CTL_DISC_BYTE;
            endcase
          end
          send_line_frame(ctl, 1'b0);
        end else if (pick < 75) begin
          repeat ($urandom_range(1, 4)) send_request(ACT_TICK, 8'($urandom));
        end else if (pick < 92) begin
          send_request(ACT_BYTE, 8'($urandom));
        end else begin
          send_request($urandom_range(1) ? ACT_OPEN : ACT_CLOSE, 8'($urandom));
        end
      end
      PH_OPEN: begin
        if (pick < 70) send_request(ACT_CLOSE, 8'($urandom));
        else send_request(2'($urandom_range(3)), 8'($urandom));
      end
      default: begin
        if (pick < 75) send_request(ACT_OPEN, 8'($urandom));
        else send_request(2'($urandom_range(3)), 8'($urandom));
      end
    endcase
  endtask

  task automatic test_ignored_when_idle();
    send_request(ACT_CLOSE, 8'hA5);
    send_request(ACT_TICK, 8'h5A);
  endtask

  // partial reply, timeout resend, then a reply that must start afresh
  task automatic test_open_with_retry();
    send_request(ACT_OPEN, 8'h00);
    send_request(ACT_OPEN, 8'hFF);
    send_request(ACT_BYTE, FRAME_FLAG);
    send_request(ACT_BYTE, FRAME_ADDR);
    send_request(ACT_BYTE, CTL_UA_BYTE);
    repeat (3) send_request(ACT_TICK, 8'h00);
    send_request(ACT_BYTE, FRAME_ADDR ^ CTL_UA_BYTE);
    send_line_frame(CTL_UA_BYTE, 1'b1);
  endtask

  task automatic test_close_by_disc();
    send_request(ACT_CLOSE, 8'h00);
    send_line_frame(CTL_DISC_BYTE, 1'b1);
  endtask

  task automatic test_open_gives_up();
    write_register(REG_TIMEOUT, 8'd1);
    write_register(REG_ATTEMPTS, 8'd2);
    settings_used++;
    send_request(ACT_OPEN, 8'h3C);
    repeat (2) send_request(ACT_TICK, 8'hC3);
  endtask

  task automatic test_random_traffic(input logic [7:0] ticks, input logic [7:0] tries,
                                     input int count);
    int target;
    write_register(REG_TIMEOUT, ticks);
    write_register(REG_ATTEMPTS, tries);
    settings_used++;
    target = line_items + count;
    while (line_items < target) random_request();
  endtask

  // longest reply timer with a single send
  task automatic test_long_timeout();
    write_register(REG_TIMEOUT, 8'd255);
    write_register(REG_ATTEMPTS, 8'd1);
    settings_used++;
    while (link_phase == PH_OPEN || link_phase == PH_OPENING || link_phase == PH_CLOSING)
      random_request();
    send_request(ACT_OPEN, 8'($urandom));
    while (link_phase == PH_OPENING) begin
      if ($urandom_range(7) == 0) send_request(ACT_BYTE, 8'($urandom));
      else send_request(ACT_TICK, 8'($urandom));
    end
  endtask

  function automatic void report_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    errors++;
  endfunction

  always @(negedge clk) out_ch.ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_checked++;
      if (tx_expected.size() == 0) begin
        $display("%0t: unexpected request, expected none, actual %0h/%b/%b/%0d", $time,
                 out_ch.tx_byte, out_ch.tx_valid, out_ch.last, out_ch.link_status);
        errors++;
      end else begin
        head_beat = tx_expected.pop_front();
        if (out_ch.tx_byte !== head_beat.tx_byte)
          report_field("tx_byte", head_beat.tx_byte, out_ch.tx_byte);
        if (out_ch.tx_valid !== head_beat.tx_valid)
          report_field("tx_valid", 8'(head_beat.tx_valid), 8'(out_ch.tx_valid));
        if (out_ch.last !== head_beat.last)
          report_field("last", 8'(head_beat.last), 8'(out_ch.last));
        if (out_ch.link_status !== head_beat.status)
          report_field("link_status", 8'(head_beat.status), 8'(out_ch.link_status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg.valid === 1'b1 && cfg.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_TICK;
    in_ch.rx_byte = 8'h00;
    cfg.valid = 1'b0;
    cfg.index = REG_TIMEOUT;
    cfg.data = 8'h00;
    gap_pct = 0;
    stall_pct = 0;
    errors = 0;
    line_items = 0;
    results_checked = 0;
    links_opened = 0;
    links_failed = 0;
    settings_used = 1;
    quiet_cycles = 0;
    link_phase = PH_IDLE;
    rx_at = RX_START;
    rx_addr_seen = 8'h00;
    rx_ctl_seen = 8'h00;
    wait_ticks = 8'h00;
    sends_done = 4'h0;
    timeout_reg = TIMEOUT_RESET;
    attempts_reg = ATTEMPTS_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_idling(13, 49);
    test_ignored_when_idle();
    test_open_with_retry();
    test_close_by_disc();
    test_open_gives_up();
    test_random_traffic(8'd2, 8'hF4, 20);
    test_random_traffic(8'd0, 8'h00, 20);
    set_idling(49, 13);
    test_random_traffic(8'd1, 8'h0F, 20);
    test_long_timeout();
    set_idling(0, 0);
    test_random_traffic(8'd3, 8'h03, 20);
    test_random_traffic(8'd6, 8'h02, 20);

    while (tx_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d link requests over %0d register settings, %0d results checked.",
             line_items, settings_used, results_checked);
    $display("Links opened %0d times and gave up opening %0d times.", links_opened,
             links_failed);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
